>>> sv/sth_pkg.sv
// Types and constants shared by the serial terminal handshake controller.
// No dependencies; every other file refers to this package by scoped names.
package sth_pkg;

  localparam int unsigned MaxTx    = 22;
  localparam int unsigned TxSizeW  = $clog2(MaxTx + 1);
  localparam int unsigned CodeW    = 4;
  localparam int unsigned CurHsW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [7:0]  TxLimit      = 8'(MaxTx);
  localparam logic [CurHsW-1:0] CurHsReset = 8'hff;
  localparam logic [CodeW-1:0]  BaudReset  = 4'd6;
  localparam logic [CodeW-1:0]  FrameReset = 4'd3;
  localparam logic [15:0] CtrlInitReq  = 16'h0004;

  localparam int unsigned StTxAckBit = 0;
  localparam int unsigned StRxBit    = 1;
  localparam int unsigned StInitBit  = 2;

  typedef enum logic [2:0] {
    PhReqInit  = 3'd0,
    PhWaitInit = 3'd1,
    PhReady    = 3'd2,
    PhSetHs    = 3'd3,
    PhSetBaud  = 3'd4,
    PhSetFrame = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    SdoBusy  = 2'd0,
    SdoOk    = 2'd1,
    SdoError = 2'd2
  } sdo_res_e;

  typedef enum logic [1:0] {
    TgtHandshake = 2'd0,
    TgtBaud      = 2'd1,
    TgtFrame     = 2'd2
  } sdo_tgt_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegHandshake = 2'd0,
    RegBaud      = 2'd1,
    RegFrame     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic             req_handshake;
    logic [CodeW-1:0] req_baud_code;
    logic [CodeW-1:0] req_frame_code;
  } cfg_t;

  typedef struct packed {
    phase_e              phase;
    logic                tx_req_toggle;
    logic                tx_ack_seen;
    logic                rx_req_seen;
    logic                rx_ack_toggle;
    logic [TxSizeW-1:0]  tx_size;
    logic [15:0]         ctrl;
    logic [CurHsW-1:0]   cur_handshake;
    logic [CodeW-1:0]    cur_baud;
    logic [CodeW-1:0]    cur_frame;
    logic                error_latch;
  } state_t;

  typedef struct packed {
    logic [15:0] status_word;
    logic [1:0]  sdo_result;
    logic [7:0]  tx_pending_count;
  } item_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic        sdo_write;
    logic [1:0]  sdo_target;
    logic [7:0]  sdo_value;
    logic [4:0]  tx_take_count;
    logic        rx_deliver;
    logic [7:0]  rx_count;
    logic        config_failed;
    logic        link_ready;
  } result_t;

endpackage

>>> sv/sth_item_if.sv
// Input request channel: valid/ready handshake carrying one status sample.
// Depends on sth_pkg.
interface sth_item_if;
  logic           valid;
  logic           ready;
  sth_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sth_result_if.sv
// Result channel: valid/ready handshake carrying one control result.
// Depends on sth_pkg.
interface sth_result_if;
  logic             valid;
  logic             ready;
  sth_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/sth_cfg.sv
// Requested-setting registers written through the plain write port.
// Depends on sth_pkg.
module sth_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sth_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sth_pkg::CfgDataW-1:0]  cfg_data_i,
  output sth_pkg::cfg_t                 cfg_o,
  output logic                          err_clr_o
);

  sth_pkg::cfg_t cfg_q, cfg_d;
  logic          hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sth_pkg::RegHandshake: begin
          cfg_d.req_handshake = cfg_data_i[0];
          hit = 1'b1;
        end
        sth_pkg::RegBaud: begin
          cfg_d.req_baud_code = cfg_data_i[sth_pkg::CodeW-1:0];
          hit = 1'b1;
        end
        sth_pkg::RegFrame: begin
          cfg_d.req_frame_code = cfg_data_i[sth_pkg::CodeW-1:0];
          hit = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.req_handshake  <= 1'b0;
      cfg_q.req_baud_code  <= sth_pkg::BaudReset;
      cfg_q.req_frame_code <= sth_pkg::FrameReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign err_clr_o = hit;

endmodule

>>> sv/sth_step.sv
// Next-state and result logic for one status sample.
// Depends on sth_pkg; purely combinational.
module sth_step (
  input  sth_pkg::state_t  state_i,
  input  sth_pkg::cfg_t    cfg_i,
  input  sth_pkg::item_t   item_i,
  output sth_pkg::state_t  state_o,
  output sth_pkg::result_t result_o
);

  sth_pkg::state_t n;
  logic            hs_diff, baud_diff, frame_diff;
  logic            acc, rxt;
  logic [7:0]      take;
  logic            wr;
  logic [1:0]      tgt;
  logic [7:0]      val;
  logic            deliver;
  logic [7:0]      rcount;

  always_comb begin
    n          = state_i;
    wr         = 1'b0;
    tgt        = sth_pkg::TgtHandshake;
    val        = 8'd0;
    deliver    = 1'b0;
    rcount     = 8'd0;
    take       = 8'd0;
    acc        = item_i.status_word[sth_pkg::StTxAckBit];
    rxt        = item_i.status_word[sth_pkg::StRxBit];
    hs_diff    = {7'd0, cfg_i.req_handshake} != state_i.cur_handshake;
    baud_diff  = cfg_i.req_baud_code != state_i.cur_baud;
    frame_diff = cfg_i.req_frame_code != state_i.cur_frame;

    unique case (state_i.phase) inside
      sth_pkg::PhReady: begin
        if (!state_i.error_latch && hs_diff) begin
          wr      = 1'b1;
          tgt     = sth_pkg::TgtHandshake;
          val     = {7'd0, cfg_i.req_handshake};
          n.phase = sth_pkg::PhSetHs;
        end else if (!state_i.error_latch && baud_diff) begin
          wr      = 1'b1;
          tgt     = sth_pkg::TgtBaud;
          val     = {4'd0, cfg_i.req_baud_code};
          n.phase = sth_pkg::PhSetBaud;
        end else if (!state_i.error_latch && frame_diff) begin
          wr      = 1'b1;
          tgt     = sth_pkg::TgtFrame;
          val     = {4'd0, cfg_i.req_frame_code};
          n.phase = sth_pkg::PhSetFrame;
        end else begin
          if (acc != state_i.tx_ack_seen) begin
            take = (item_i.tx_pending_count < sth_pkg::TxLimit) ?
                   item_i.tx_pending_count : sth_pkg::TxLimit;
            n.tx_size = take[sth_pkg::TxSizeW-1:0];
            if (take != 8'd0) begin
              n.tx_req_toggle = ~state_i.tx_req_toggle;
              n.tx_ack_seen   = acc;
            end
          end
          if (rxt != state_i.rx_req_seen) begin
            n.rx_req_seen   = rxt;
            deliver         = 1'b1;
            rcount          = item_i.status_word[15:8];
            n.rx_ack_toggle = ~state_i.rx_ack_toggle;
          end
          n.ctrl = {8'(n.tx_size), 6'd0, n.rx_ack_toggle, n.tx_req_toggle};
        end
      end
      sth_pkg::PhWaitInit: begin
        if (!item_i.status_word[sth_pkg::StInitBit]) begin
          n.tx_ack_seen = 1'b1;
          n.ctrl        = 16'd0;
          n.phase       = sth_pkg::PhReady;
        end
      end
      sth_pkg::PhSetHs, sth_pkg::PhSetBaud, sth_pkg::PhSetFrame: begin
        case (item_i.sdo_result)
          sth_pkg::SdoOk: begin
            n.phase = sth_pkg::PhReqInit;
            if (state_i.phase == sth_pkg::PhSetHs) begin
              n.cur_handshake = {7'd0, cfg_i.req_handshake};
            end else if (state_i.phase == sth_pkg::PhSetBaud) begin
              n.cur_baud = cfg_i.req_baud_code;
            end else begin
              n.cur_frame = cfg_i.req_frame_code;
            end
          end
          sth_pkg::SdoError: begin
            n.error_latch = 1'b1;
            n.phase       = sth_pkg::PhReqInit;
          end
          default: n.phase = state_i.phase;
        endcase
      end
      default: begin
        if (item_i.status_word[sth_pkg::StInitBit]) begin
          n.ctrl  = 16'd0;
          n.phase = sth_pkg::PhWaitInit;
        end else begin
          n.ctrl  = sth_pkg::CtrlInitReq;
          n.phase = sth_pkg::PhReqInit;
        end
      end
    endcase
  end

  assign state_o                = n;
  assign result_o.control_word  = n.ctrl;
  assign result_o.sdo_write     = wr;
  assign result_o.sdo_target    = tgt;
  assign result_o.sdo_value     = val;
  assign result_o.tx_take_count = take[4:0];
  assign result_o.rx_deliver    = deliver;
  assign result_o.rx_count      = rcount;
  assign result_o.config_failed = n.error_latch;
  assign result_o.link_ready    = (n.phase == sth_pkg::PhReady);

endmodule

>>> sv/serial_terminal_handshake_fsm_core.sv
// Serial terminal handshake controller, top level.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per clock while the result side is ready; the result register frees itself when taken.
// Reset (rst_ni low, asynchronous): phase request-init, toggles and control word 0,
// current handshake 0xff, baud and frame 0, error latch 0, no result pending.
// Depends on sth_pkg, sth_item_if, sth_result_if, sth_cfg, sth_step.
module serial_terminal_handshake_fsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sth_item_if.sink                      item_i,
  sth_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [sth_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sth_pkg::CfgDataW-1:0]  cfg_data_i
);

  sth_pkg::cfg_t    cfg;
  logic             err_clr;
  sth_pkg::state_t  state_q, state_d, step_state;
  sth_pkg::result_t res_q, step_res;
  logic             res_valid_q, res_valid_d;
  logic             accept;

  sth_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .err_clr_o  (err_clr)
  );

  sth_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (item_i.data),
    .state_o  (step_state),
    .result_o (step_res)
  );

  assign item_i.ready = !res_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  always_comb begin
    state_d = accept ? step_state : state_q;
    if (err_clr) begin
      state_d.error_latch = 1'b0;
    end
    res_valid_d = accept || (res_valid_q && !result_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= sth_pkg::PhReqInit;
      state_q.tx_req_toggle <= 1'b0;
      state_q.tx_ack_seen   <= 1'b0;
      state_q.rx_req_seen   <= 1'b0;
      state_q.rx_ack_toggle <= 1'b0;
      state_q.tx_size       <= '0;
      state_q.ctrl          <= 16'd0;
      state_q.cur_handshake <= sth_pkg::CurHsReset;
      state_q.cur_baud      <= '0;
      state_q.cur_frame     <= '0;
      state_q.error_latch   <= 1'b0;
      res_valid_q           <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= step_res;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

>>> tb/serial_terminal_handshake_fsm_core_tb.sv
// Self-checking bench for serial_terminal_handshake_fsm_core: init sequencing, settings
// writes and tx/rx toggle handshakes against a per-request predictor, with random stalls.
// Depends on sth_pkg, sth_item_if, sth_result_if and the core RTL.
module serial_terminal_handshake_fsm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam logic [1:0] SdoUndef = 2'd3;
  localparam logic [sth_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sth_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [sth_pkg::CfgDataW-1:0] cfg_data_i = '0;

  sth_item_if item_ch ();
  sth_result_if result_ch ();

  serial_terminal_handshake_fsm_core dut (
    .clk_i (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .result_o (result_ch),
    .cfg_we_i (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted controller state
  sth_pkg::cfg_t req_cfg;
  sth_pkg::phase_e ph;
  logic tx_req_t, tx_ack_s, rx_req_s, rx_ack_t;
  logic [7:0] tx_sz;
  logic [15:0] ctrl;
  logic [7:0] cur_hs, cur_bd, cur_fr;
  logic err_latch;

  sth_pkg::result_t control_results_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  int unsigned rx_hold = 0;

  function automatic void reset_controller();
    req_cfg.req_handshake = 1'b0;
    req_cfg.req_baud_code = sth_pkg::BaudReset;
    req_cfg.req_frame_code = sth_pkg::FrameReset;
    ph = sth_pkg::PhReqInit;
    tx_req_t = 1'b0;
    tx_ack_s = 1'b0;
    rx_req_s = 1'b0;
    rx_ack_t = 1'b0;
    tx_sz = '0;
    ctrl = '0;
    cur_hs = sth_pkg::CurHsReset;
    cur_bd = '0;
    cur_fr = '0;
    err_latch = 1'b0;
  endfunction

  function automatic sth_pkg::result_t step_controller(input sth_pkg::item_t it);
    sth_pkg::result_t r;
    logic [7:0] take;
    r = '0;
    take = '0;
    case (ph) inside
      sth_pkg::PhReady: begin
        if (!err_latch && {7'b0, req_cfg.req_handshake} != cur_hs) begin
          r.sdo_write = 1'b1;
          r.sdo_target = sth_pkg::TgtHandshake;
          r.sdo_value = {7'b0, req_cfg.req_handshake};
          ph = sth_pkg::PhSetHs;
        end else if (!err_latch && {4'b0, req_cfg.req_baud_code} != cur_bd) begin
          r.sdo_write = 1'b1;
          r.sdo_target = sth_pkg::TgtBaud;
          r.sdo_value = {4'b0, req_cfg.req_baud_code};
          ph = sth_pkg::PhSetBaud;
        end else if (!err_latch && {4'b0, req_cfg.req_frame_code} != cur_fr) begin
          r.sdo_write = 1'b1;
          r.sdo_target = sth_pkg::TgtFrame;
          r.sdo_value = {4'b0, req_cfg.req_frame_code};
          ph = sth_pkg::PhSetFrame;
        end else begin
          if (it.status_word[sth_pkg::StTxAckBit] != tx_ack_s) begin
            tx_sz = (it.tx_pending_count < sth_pkg::TxLimit) ?
                    it.tx_pending_count : sth_pkg::TxLimit;
            take = tx_sz;
            if (tx_sz != 0) begin
              tx_req_t = ~tx_req_t;
              tx_ack_s = it.status_word[sth_pkg::StTxAckBit];
            end
          end
          if (it.status_word[sth_pkg::StRxBit] != rx_req_s) begin
            rx_req_s = it.status_word[sth_pkg::StRxBit];
            r.rx_deliver = 1'b1;
            r.rx_count = it.status_word[15:8];
            rx_ack_t = ~rx_ack_t;
          end
          ctrl = {tx_sz, 6'b0, rx_ack_t, tx_req_t};
        end
      end
      sth_pkg::PhWaitInit: begin
        if (!it.status_word[sth_pkg::StInitBit]) begin
          tx_ack_s = 1'b1;
          ctrl = '0;
          ph = sth_pkg::PhReady;
        end
      end
      sth_pkg::PhSetHs, sth_pkg::PhSetBaud, sth_pkg::PhSetFrame: begin
        if (it.sdo_result == sth_pkg::SdoOk) begin
          case (ph)
            sth_pkg::PhSetHs: cur_hs = {7'b0, req_cfg.req_handshake};
            sth_pkg::PhSetBaud: cur_bd = {4'b0, req_cfg.req_baud_code};
            default: cur_fr = {4'b0, req_cfg.req_frame_code};
          endcase
          ph = sth_pkg::PhReqInit;
        end else if (it.sdo_result == sth_pkg::SdoError) begin
          err_latch = 1'b1;
          ph = sth_pkg::PhReqInit;
        end
      end
      default: begin
        if (it.status_word[sth_pkg::StInitBit]) begin
          ctrl = '0;
          ph = sth_pkg::PhWaitInit;
        end else begin
          ctrl = sth_pkg::CtrlInitReq;
          ph = sth_pkg::PhReqInit;
        end
      end
    endcase
    r.control_word = ctrl;
    r.tx_take_count = take[4:0];
    r.config_failed = err_latch;
    r.link_ready = (ph == sth_pkg::PhReady);
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (mismatches < 50)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // result checking, request prediction and register tracking, in that order
  always @(posedge clk_i) begin
    sth_pkg::result_t want;
    sth_pkg::result_t got;
    if (rst_ni) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (control_results_due.size() == 0) begin
          if (mismatches < 50)
            $display("%0t: unexpected result, expected none, got 0x%0h", $time, got);
          mismatches++;
        end else begin
          want = control_results_due.pop_front();
          check_field("control_word", want.control_word, got.control_word);
          check_field("sdo_write", want.sdo_write, got.sdo_write);
          check_field("sdo_target", want.sdo_target, got.sdo_target);
          check_field("sdo_value", want.sdo_value, got.sdo_value);
          check_field("tx_take_count", want.tx_take_count, got.tx_take_count);
          check_field("rx_deliver", want.rx_deliver, got.rx_deliver);
          check_field("rx_count", want.rx_count, got.rx_count);
          check_field("config_failed", want.config_failed, got.config_failed);
          check_field("link_ready", want.link_ready, got.link_ready);
        end
      end
      if (item_ch.valid && item_ch.ready)
        control_results_due.push_back(step_controller(item_ch.data));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sth_pkg::RegHandshake: begin
            req_cfg.req_handshake = cfg_data_i[0];
            err_latch = 1'b0;
          end
          sth_pkg::RegBaud: begin
            req_cfg.req_baud_code = cfg_data_i;
            err_latch = 1'b0;
          end
          sth_pkg::RegFrame: begin
            req_cfg.req_frame_code = cfg_data_i;
            err_latch = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("serial_terminal_handshake_fsm_core_tb: errors");
      $finish;
    end
  end

  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // result-side backpressure
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      result_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      result_ch.ready <= 1'b1;
      rx_hold = idle_len(receiver_calm);
    end
  end

  task automatic send_status(input sth_pkg::item_t it);
    int unsigned gap;
    gap = idle_len(sender_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (control_results_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sth_pkg::CfgIdxW-1:0] idx,
                           input logic [sth_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic sth_pkg::item_t mk(input logic [15:0] status, input logic [1:0] sdo,
                                        input logic [7:0] pending);
    sth_pkg::item_t it;
    it.status_word = status;
    it.sdo_result = sdo;
    it.tx_pending_count = pending;
    return it;
  endfunction

  // mostly requests that follow the terminal protocol from the predicted phase
  function automatic sth_pkg::item_t next_status();
    sth_pkg::item_t it;
    int unsigned r;
    it.status_word = 16'($urandom);
    it.sdo_result = 2'($urandom);
    it.tx_pending_count = 8'($urandom);
    if ($urandom_range(0, 99) < 12) return it;
    case (ph)
      sth_pkg::PhReqInit:
        it.status_word[sth_pkg::StInitBit] = ($urandom_range(0, 9) < 6);
      sth_pkg::PhWaitInit:
        it.status_word[sth_pkg::StInitBit] = ($urandom_range(0, 1) == 0);
      sth_pkg::PhReady: begin
        it.status_word[sth_pkg::StTxAckBit] = $urandom_range(0, 1) ? ~tx_ack_s : tx_ack_s;
        it.status_word[sth_pkg::StRxBit] = ($urandom_range(0, 2) == 0) ? ~rx_req_s : rx_req_s;
        r = $urandom_range(0, 9);
        case (r) inside
          0: it.tx_pending_count = '0;
          1: it.tx_pending_count = sth_pkg::TxLimit;
          2: it.tx_pending_count = sth_pkg::TxLimit - 8'd1;
          3: it.tx_pending_count = sth_pkg::TxLimit + 8'd1;
          4: it.tx_pending_count = 8'hff;
          5, 6: it.tx_pending_count = 8'($urandom_range(1, sth_pkg::MaxTx - 1));
          default: ;
        endcase
      end
      default: begin
        r = $urandom_range(0, 99);
        it.sdo_result = (r < 45) ? sth_pkg::SdoBusy :
                        (r < 80) ? sth_pkg::SdoOk :
                        (r < 88) ? sth_pkg::SdoError : SdoUndef;
      end
    endcase
    return it;
  endfunction

  task automatic test_init_and_writes();
    send_status(mk(16'h0000, sth_pkg::SdoError, 8'hff));
    send_status(mk(16'h0004, sth_pkg::SdoOk, 8'h00));
    send_status(mk(16'hffff, sth_pkg::SdoError, 8'hff));
    send_status(mk(16'hfffb, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, SdoUndef, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoOk, 8'h00));
    send_status(mk(16'h0004, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoError, 8'h00));
  endtask

  task automatic test_toggle_handshakes();
    send_status(mk(16'h0004, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    // accepted toggle moved but host has nothing queued
    send_status(mk(16'h0000, sth_pkg::SdoBusy, 8'h00));
    send_status(mk(16'hab02, sth_pkg::SdoBusy, 8'hff));
    send_status(mk(16'h0001, sth_pkg::SdoError, sth_pkg::TxLimit));
    send_status(mk(16'hff02, SdoUndef, sth_pkg::TxLimit - 8'd1));
    send_status(mk(16'h0003, sth_pkg::SdoBusy, sth_pkg::TxLimit + 8'd1));
    send_status(mk(16'hffff, sth_pkg::SdoOk, 8'h01));
    send_status(mk(16'h00fe, sth_pkg::SdoBusy, 8'hff));
  endtask

  task automatic test_config_phases();
    logic [sth_pkg::CfgDataW-1:0] hs_d, bd_d, fr_d;
    // out-of-range index must leave the error latch alone
    wait_results_drained();
    write_reg(RegUnused, 4'hf);
    send_status(next_status());
    send_status(next_status());
    for (int p = 0; p < 12; p++) begin
      wait_results_drained();
      hs_d = 4'($urandom);
      bd_d = 4'($urandom);
      fr_d = 4'($urandom);
      case (p)
        0: begin hs_d[0] = 1'b0; bd_d = 4'd1; fr_d = 4'd1; end
        1: begin hs_d[0] = 1'b1; bd_d = 4'd10; fr_d = 4'd13; end
        2: begin hs_d[0] = 1'b0; bd_d = 4'd15; fr_d = 4'd15; end
        3: begin hs_d[0] = 1'b1; bd_d = 4'd0; fr_d = 4'd0; end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(RegUnused, 4'($urandom));
      write_reg(sth_pkg::RegHandshake, hs_d);
      write_reg(sth_pkg::RegBaud, bd_d);
      write_reg(sth_pkg::RegFrame, fr_d);
      sender_calm = (p % 4 == 1) || (p % 4 == 2);
      receiver_calm = (p % 4 == 2) || (p % 4 == 3);
      repeat (160) send_status(next_status());
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    reset_controller();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_init_and_writes();
    test_toggle_handshakes();
    test_config_phases();

    wait_results_drained();
    repeat (3) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("serial_terminal_handshake_fsm_core_tb: clean");
    end else begin
      $display("serial_terminal_handshake_fsm_core_tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sth_pkg.sv
sv/sth_item_if.sv
sv/sth_result_if.sv
sv/sth_cfg.sv
sv/sth_step.sv
sv/serial_terminal_handshake_fsm_core.sv
tb/serial_terminal_handshake_fsm_core_tb.sv
